FILE: design/sif_pkg.sv
package sif_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned OP_W    = 2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_LOAD_FIRST  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_SECOND = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE     = 2'd2;

  // One result beat
  typedef struct packed {
    logic signed [VALUE_W-1:0] common_value;
    logic                      empty_result;
    logic                      from_second_set;
    logic                      last_result;
  } res_t;

endpackage

FILE: design/set_intersection_filter_core.sv
// Nested-loop set intersection over two on-chip stores of SET_DEPTH signed
// 32-bit elements. Load beats (operation 0 or 1) append to the first or second
// store and are dropped once a store is full; operation 3 is taken and
// ignored. A compute beat scans the larger store (the second on a tie) and,
// for each scanned element, reads the other store one entry per cycle until a
// match or its end; the input is not ready while a compute runs. Every
// scanned element with a match is given in stored order, duplicates kept,
// with last_result on the final one; with no match a single beat with
// empty_result set is given. Both counts clear after a compute. Results
// leave through an output register, so loads are taken while a result waits.
module set_intersection_filter_core
  import sif_pkg::*;
#(
  parameter int unsigned SET_DEPTH = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [OP_W-1:0]           in_operation,
  input  logic signed [VALUE_W-1:0] in_element_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [VALUE_W-1:0] out_common_value,
  output logic                      out_empty_result,
  output logic                      out_from_second_set,
  output logic                      out_last_result
);

  localparam int unsigned AW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
  localparam int unsigned CW = $clog2(SET_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(SET_DEPTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_INNER = 3'd2;
  localparam logic [2:0] S_EMIT  = 3'd3;
  localparam logic [2:0] S_FINAL = 3'd4;

  logic [2:0]                state_r, state_nxt;
  logic [CW-1:0]             first_cnt_r, first_cnt_nxt;
  logic [CW-1:0]             second_cnt_r, second_cnt_nxt;
  logic                      sel_second_r, sel_second_nxt;
  logic [CW-1:0]             scan_n_r, scan_n_nxt;
  logic [CW-1:0]             other_n_r, other_n_nxt;
  logic [CW-1:0]             i_r, i_nxt;
  logic [CW-1:0]             j_r, j_nxt;
  logic                      cmp_vld_r, cmp_vld_nxt;
  logic                      match_r, match_nxt;
  logic                      pend_vld_r, pend_vld_nxt;
  logic signed [VALUE_W-1:0] pend_val_r, pend_val_nxt;

  logic                      in_fire;
  logic                      wr_first, wr_second;
  logic                      scan_rd, other_rd;
  logic                      first_rd_en, second_rd_en;
  logic [AW-1:0]             first_rd_addr, second_rd_addr;
  logic signed [VALUE_W-1:0] first_dout, second_dout;
  logic signed [VALUE_W-1:0] scan_dout, other_dout;
  logic                      hit, found, inner_done;
  logic                      out_free, push;
  res_t                      push_res;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  // Append loads while the store has room
  assign wr_first  = in_fire && (in_operation == OP_LOAD_FIRST) && (first_cnt_r < DEPTH_C);
  assign wr_second = in_fire && (in_operation == OP_LOAD_SECOND) && (second_cnt_r < DEPTH_C);

  // Route scan and other reads to the two stores
  assign scan_rd  = (state_r == S_FETCH);
  assign other_rd = (state_r == S_INNER) && !found && (j_r < other_n_r);

  assign first_rd_en    = sel_second_r ? other_rd : scan_rd;
  assign second_rd_en   = sel_second_r ? scan_rd : other_rd;
  assign first_rd_addr  = sel_second_r ? j_r[AW-1:0] : i_r[AW-1:0];
  assign second_rd_addr = sel_second_r ? i_r[AW-1:0] : j_r[AW-1:0];

  assign scan_dout  = sel_second_r ? second_dout : first_dout;
  assign other_dout = sel_second_r ? first_dout : second_dout;

  // Compare the returned other entry against the held scan element
  assign hit        = cmp_vld_r && (other_dout == scan_dout);
  assign found      = match_r || hit;
  assign inner_done = found || ((j_r == other_n_r) && !cmp_vld_r);

  sif_set_mem #(
    .DEPTH (SET_DEPTH),
    .AW    (AW)
  ) u_first_mem (
    .clk     (clk),
    .wr_en   (wr_first),
    .wr_addr (first_cnt_r[AW-1:0]),
    .wr_data (in_element_value),
    .rd_en   (first_rd_en),
    .rd_addr (first_rd_addr),
    .rd_data (first_dout)
  );

  sif_set_mem #(
    .DEPTH (SET_DEPTH),
    .AW    (AW)
  ) u_second_mem (
    .clk     (clk),
    .wr_en   (wr_second),
    .wr_addr (second_cnt_r[AW-1:0]),
    .wr_data (in_element_value),
    .rd_en   (second_rd_en),
    .rd_addr (second_rd_addr),
    .rd_data (second_dout)
  );

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    first_cnt_nxt  = first_cnt_r;
    second_cnt_nxt = second_cnt_r;
    sel_second_nxt = sel_second_r;
    scan_n_nxt     = scan_n_r;
    other_n_nxt    = other_n_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    cmp_vld_nxt    = cmp_vld_r;
    match_nxt      = match_r;
    pend_vld_nxt   = pend_vld_r;
    pend_val_nxt   = pend_val_r;
    push           = 1'b0;
    push_res       = '{common_value: pend_val_r, empty_result: 1'b0,
                       from_second_set: sel_second_r, last_result: 1'b0};

    case (state_r)
      S_IDLE: begin
        if (wr_first) begin
          first_cnt_nxt = first_cnt_r + 1'b1;
        end
        if (wr_second) begin
          second_cnt_nxt = second_cnt_r + 1'b1;
        end
        if (in_fire && (in_operation == OP_COMPUTE)) begin
          pend_vld_nxt = 1'b0;
          i_nxt        = '0;
          if (first_cnt_r > second_cnt_r) begin
            sel_second_nxt = 1'b0;
            scan_n_nxt     = first_cnt_r;
            other_n_nxt    = second_cnt_r;
            state_nxt      = S_FETCH;
          end else begin
            sel_second_nxt = 1'b1;
            scan_n_nxt     = second_cnt_r;
            other_n_nxt    = first_cnt_r;
            state_nxt      = (second_cnt_r == '0) ? S_FINAL : S_FETCH;
          end
        end
      end

      S_FETCH: begin
        j_nxt       = '0;
        cmp_vld_nxt = 1'b0;
        match_nxt   = 1'b0;
        state_nxt   = S_INNER;
      end

      S_INNER: begin
        match_nxt   = found;
        cmp_vld_nxt = other_rd;
        if (other_rd) begin
          j_nxt = j_r + 1'b1;
        end
        if (inner_done) begin
          state_nxt = S_EMIT;
        end
      end

      S_EMIT: begin
        // Hold a match until the next one or the end shows whether it is last
        if (!(match_r && pend_vld_r && !out_free)) begin
          if (match_r) begin
            push         = pend_vld_r;
            pend_vld_nxt = 1'b1;
            pend_val_nxt = scan_dout;
          end
          i_nxt     = i_r + 1'b1;
          state_nxt = ((i_r + 1'b1) == scan_n_r) ? S_FINAL : S_FETCH;
        end
      end

      S_FINAL: begin
        if (out_free) begin
          push = 1'b1;
          if (pend_vld_r) begin
            push_res = '{common_value: pend_val_r, empty_result: 1'b0,
                         from_second_set: sel_second_r, last_result: 1'b1};
          end else begin
            push_res = '{common_value: '0, empty_result: 1'b1,
                         from_second_set: sel_second_r, last_result: 1'b1};
          end
          pend_vld_nxt   = 1'b0;
          first_cnt_nxt  = '0;
          second_cnt_nxt = '0;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      first_cnt_r  <= '0;
      second_cnt_r <= '0;
      cmp_vld_r    <= 1'b0;
      match_r      <= 1'b0;
      pend_vld_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      first_cnt_r  <= first_cnt_nxt;
      second_cnt_r <= second_cnt_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      match_r      <= match_nxt;
      pend_vld_r   <= pend_vld_nxt;
    end
  end

  // Scan bookkeeping and pending payload
  always_ff @(posedge clk) begin
    sel_second_r <= sel_second_nxt;
    scan_n_r     <= scan_n_nxt;
    other_n_r    <= other_n_nxt;
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    pend_val_r   <= pend_val_nxt;
  end

  sif_out_reg u_out_reg (
    .clk                 (clk),
    .rst_n               (rst_n),
    .push                (push),
    .res                 (push_res),
    .free                (out_free),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_common_value    (out_common_value),
    .out_empty_result    (out_empty_result),
    .out_from_second_set (out_from_second_set),
    .out_last_result     (out_last_result)
  );

endmodule

FILE: design/sif_set_mem.sv
module sif_set_mem
  import sif_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic signed [VALUE_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic signed [VALUE_W-1:0] rd_data
);

  logic signed [VALUE_W-1:0] mem [DEPTH];
  logic signed [VALUE_W-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, held while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/sif_out_reg.sv
module sif_out_reg
  import sif_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  res_t                      res,
  output logic                      free,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [VALUE_W-1:0] out_common_value,
  output logic                      out_empty_result,
  output logic                      out_from_second_set,
  output logic                      out_last_result
);

  logic vld_r;
  logic vld_nxt;
  res_t res_r;

  // Slot can take a beat when empty or when its beat leaves this cycle
  assign free = !vld_r || out_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (push) begin
      vld_nxt = 1'b1;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Load payload on push
  always_ff @(posedge clk) begin
    if (push) begin
      res_r <= res;
    end
  end

  assign out_valid           = vld_r;
  assign out_common_value    = res_r.common_value;
  assign out_empty_result    = res_r.empty_result;
  assign out_from_second_set = res_r.from_second_set;
  assign out_last_result     = res_r.last_result;

endmodule
